[sv/ktx_header_parse_extract_core_defines.svh]
// ----------------------------------------------------------------------------
// KTX header parser assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef KTX_HEADER_PARSE_EXTRACT_CORE_DEFINES_SVH
`define KTX_HEADER_PARSE_EXTRACT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Consequent checked in the same cycle as the antecedent.
`define KHPE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define KHPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KHPE_ASSERT_SAME(lbl, ante, cons, msg)
`define KHPE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[sv/khpe_pkg.sv]
// ----------------------------------------------------------------------------
// KTX header parser package
// Phase encoding, result codes, header offsets and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package khpe_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_KVSKIP,
    PH_SIZE,
    PH_PAYLOAD,
    PH_DONE
  } phase_e;

  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_IDENT  = 2'd0;
  localparam logic [1:0] ERR_ENDIAN = 2'd1;
  localparam logic [1:0] ERR_ARRAY  = 2'd2;
  localparam logic [1:0] ERR_FACES  = 2'd3;

  localparam logic [31:0] ENDIAN_TAG = 32'h0403_0201;
  localparam logic [31:0] RGB_FORMAT = 32'h0000_1907;

  localparam int unsigned POS_W = 6;

  localparam logic [POS_W-1:0] POS_IDENT_END = 6'd12;
  localparam logic [POS_W-1:0] POS_ENDIAN    = 6'd15;
  localparam logic [POS_W-1:0] POS_TYPE      = 6'd19;
  localparam logic [POS_W-1:0] POS_FORMAT    = 6'd27;
  localparam logic [POS_W-1:0] POS_IFORMAT   = 6'd31;
  localparam logic [POS_W-1:0] POS_WIDTH     = 6'd39;
  localparam logic [POS_W-1:0] POS_HEIGHT    = 6'd43;
  localparam logic [POS_W-1:0] POS_ARRAY     = 6'd51;
  localparam logic [POS_W-1:0] POS_FACES     = 6'd55;
  localparam logic [POS_W-1:0] POS_KVLEN     = 6'd63;
  localparam logic [POS_W-1:0] POS_SIZE_END  = 6'd3;

  typedef struct packed {
    logic       hdr_step;
    logic       kv_step;
    logic       size_step;
    logic       pay_step;
    logic       emit;
    logic [1:0] kind;
    logic [1:0] err_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       chk_fail;
    logic [1:0] chk_code;
    logic       hdr_end;
    logic       kv_zero;
    logic       kv_last;
    logic       size_done;
    logic       pay_zero;
    logic       pay_last;
  } dp_status_t;

  function automatic logic [7:0] ident_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'hAB;
      4'd1:    b = 8'h4B;
      4'd2:    b = 8'h54;
      4'd3:    b = 8'h58;
      4'd4:    b = 8'h20;
      4'd5:    b = 8'h31;
      4'd6:    b = 8'h31;
      4'd7:    b = 8'hBB;
      4'd8:    b = 8'h0D;
      4'd9:    b = 8'h0A;
      4'd10:   b = 8'h1A;
      4'd11:   b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (|v[31:16]) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

`default_nettype wire

[sv/khpe_ctrl.sv]
// ----------------------------------------------------------------------------
// KTX header parser controller
// Parse phase state machine, handshake and result register valid.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ktx_header_parse_extract_core_defines.svh"

module khpe_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  start_of_file_i,
  input  wire                  out_ready_i,
  input  wire khpe_pkg::dp_status_t status_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output khpe_pkg::ctrl_cmd_t  cmd_o
);
  import khpe_pkg::*;

  phase_e     state_q, state_d;
  phase_e     phase_eff;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  ctrl_cmd_t  cmd;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign phase_eff   = start_of_file_i ? PH_HEADER : state_q;
  assign cmd_o       = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    if (accept) begin
      state_d = phase_eff;
      case (phase_eff)
        PH_HEADER: begin
          cmd.hdr_step = 1'b1;
          if (status_i.chk_fail) begin
            cmd.emit     = 1'b1;
            cmd.kind     = KIND_ERROR;
            cmd.err_code = status_i.chk_code;
            state_d      = PH_DONE;
          end else if (status_i.hdr_end) begin
            state_d = status_i.kv_zero ? PH_SIZE : PH_KVSKIP;
          end
        end
        PH_KVSKIP: begin
          cmd.kv_step = 1'b1;
          if (status_i.kv_last) begin
            state_d = PH_SIZE;
          end
        end
        PH_SIZE: begin
          cmd.size_step = 1'b1;
          if (status_i.size_done) begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_SUMMARY;
            state_d  = status_i.pay_zero ? PH_DONE : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          cmd.pay_step = 1'b1;
          cmd.emit     = 1'b1;
          cmd.kind     = KIND_PAYLOAD;
          if (status_i.pay_last) begin
            state_d = PH_DONE;
          end
        end
        default: begin
          state_d = phase_eff;
        end
      endcase
    end
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  `KHPE_ASSERT_SAME(a_emit_on_accept, cmd.emit, accept,
                    "result issued without an accepted byte")
  `KHPE_ASSERT_NEXT(a_idle_stays_quiet,
                    accept && !start_of_file_i && (state_q == PH_DONE || state_q == PH_IDLE),
                    (state_q == PH_DONE || state_q == PH_IDLE) && !out_valid_q,
                    "parse resumed without a start flag")
  `KHPE_ASSERT_NEXT(a_summary_then_payload,
                    accept && !start_of_file_i && state_q == PH_SIZE &&
                    status_i.size_done && !status_i.pay_zero,
                    state_q == PH_PAYLOAD && out_valid_q,
                    "summary not followed by payload phase")

endmodule

`default_nettype wire

[sv/khpe_dp.sv]
// ----------------------------------------------------------------------------
// KTX header parser datapath
// Byte position, word assembly, header fields, counters, size product and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module khpe_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_of_file_i,
  input  wire  [7:0]           file_byte_i,
  input  wire khpe_pkg::ctrl_cmd_t cmd_i,
  output khpe_pkg::dp_status_t status_o,
  output logic [1:0]           result_kind_o,
  output logic [1:0]           error_code_o,
  output logic [15:0]          image_width_o,
  output logic [15:0]          image_height_o,
  output logic [2:0]           channel_count_o,
  output logic [31:0]          compression_format_o,
  output logic [33:0]          data_size_o,
  output logic [7:0]           payload_byte_o,
  output logic                 last_payload_o
);
  import khpe_pkg::*;

  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] pos_eff;
  logic [31:0]      wa_q;
  logic [31:0]      w_next;
  logic             type_nz_q;
  logic [31:0]      fmt_q;
  logic [31:0]      ifmt_q;
  logic [31:0]      width_q;
  logic [31:0]      height_q;
  logic [31:0]      kv_q;
  logic [31:0]      pay_q;
  logic [15:0]      wd_sat;
  logic [15:0]      ht_sat;
  logic [2:0]       chan;
  logic [31:0]      prod_wh_q;
  logic [33:0]      prod_q;
  dp_status_t       st;

  logic [1:0]  kind_q;
  logic [1:0]  err_q;
  logic [15:0] wd_out_q;
  logic [15:0] ht_out_q;
  logic [2:0]  ch_out_q;
  logic [31:0] fmt_out_q;
  logic [33:0] size_out_q;
  logic [7:0]  byte_out_q;
  logic        last_out_q;

  assign pos_eff = start_of_file_i ? '0 : pos_q;
  assign w_next  = {file_byte_i, wa_q[31:8]};
  assign wd_sat  = sat16(width_q);
  assign ht_sat  = sat16(height_q);
  assign chan    = (fmt_q == RGB_FORMAT) ? 3'd3 : 3'd4;

  always_comb begin
    st           = '0;
    st.chk_code  = ERR_IDENT;
    if (pos_eff < POS_IDENT_END) begin
      st.chk_fail = (file_byte_i != ident_byte(pos_eff[3:0]));
      st.chk_code = ERR_IDENT;
    end else begin
      case (pos_eff)
        POS_ENDIAN: begin
          st.chk_fail = (w_next != ENDIAN_TAG);
          st.chk_code = ERR_ENDIAN;
        end
        POS_ARRAY: begin
          st.chk_fail = (w_next != 32'd0);
          st.chk_code = ERR_ARRAY;
        end
        POS_FACES: begin
          st.chk_fail = (w_next != 32'd1) && (w_next != 32'd6);
          st.chk_code = ERR_FACES;
        end
        default: begin
          st.chk_fail = 1'b0;
        end
      endcase
    end
    st.hdr_end   = (pos_eff == POS_KVLEN);
    st.kv_zero   = (w_next == 32'd0);
    st.kv_last   = (kv_q == 32'd1);
    st.size_done = (pos_eff == POS_SIZE_END);
    st.pay_zero  = (w_next == 32'd0);
    st.pay_last  = (pay_q == 32'd1);
  end

  assign status_o = st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.hdr_step) begin
      pos_q <= st.hdr_end ? '0 : pos_eff + POS_W'(1);
    end else if (cmd_i.kv_step && st.kv_last) begin
      pos_q <= '0;
    end else if (cmd_i.size_step) begin
      pos_q <= pos_eff + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_step || cmd_i.size_step) begin
      wa_q <= w_next;
    end
    if (cmd_i.hdr_step) begin
      case (pos_eff)
        POS_TYPE:    type_nz_q <= (w_next != 32'd0);
        POS_FORMAT:  fmt_q     <= w_next;
        POS_IFORMAT: ifmt_q    <= w_next;
        POS_WIDTH:   width_q   <= w_next;
        POS_HEIGHT:  height_q  <= w_next;
        POS_KVLEN:   kv_q      <= w_next;
        default: begin
        end
      endcase
    end
    if (cmd_i.kv_step) begin
      kv_q <= kv_q - 32'd1;
    end
    if (cmd_i.size_step && st.size_done) begin
      pay_q <= w_next;
    end
    if (cmd_i.pay_step) begin
      pay_q <= pay_q - 32'd1;
    end
    // Size product settles long before the level-0 size word is complete.
    prod_wh_q <= {16'd0, wd_sat} * {16'd0, ht_sat};
    prod_q    <= (chan == 3'd3) ? ({1'b0, prod_wh_q, 1'b0} + {2'b00, prod_wh_q})
                                : {prod_wh_q, 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q     <= cmd_i.kind;
      err_q      <= '0;
      wd_out_q   <= '0;
      ht_out_q   <= '0;
      ch_out_q   <= '0;
      fmt_out_q  <= '0;
      size_out_q <= '0;
      byte_out_q <= '0;
      last_out_q <= 1'b0;
      if (cmd_i.kind == KIND_SUMMARY) begin
        wd_out_q   <= wd_sat;
        ht_out_q   <= ht_sat;
        ch_out_q   <= chan;
        fmt_out_q  <= type_nz_q ? 32'd0 : ifmt_q;
        size_out_q <= type_nz_q ? prod_q : {2'b00, w_next};
      end else if (cmd_i.kind == KIND_PAYLOAD) begin
        byte_out_q <= file_byte_i;
        last_out_q <= st.pay_last;
      end else begin
        err_q <= cmd_i.err_code;
      end
    end
  end

  assign result_kind_o        = kind_q;
  assign error_code_o         = err_q;
  assign image_width_o        = wd_out_q;
  assign image_height_o       = ht_out_q;
  assign channel_count_o      = ch_out_q;
  assign compression_format_o = fmt_out_q;
  assign data_size_o          = size_out_q;
  assign payload_byte_o       = byte_out_q;
  assign last_payload_o       = last_out_q;

endmodule

`default_nettype wire

[sv/ktx_header_parse_extract_core.sv]
// ----------------------------------------------------------------------------
// KTX version 1 header parser and level-0 extractor
// Checks the file header, reports a summary or an error, then forwards the
// level-0 face-0 image bytes.
//
//   channel  handshake               payload
//   in       in_valid_i / in_ready_o  start_of_file_i, file_byte_i
//   out      out_valid_o / out_ready_i result_kind_o .. last_payload_o
//
// One byte is taken per cycle; each byte yields at most one transaction.
// A byte is taken when the result register is empty or its transaction
// completes in the same cycle; a held result with out_ready_i low stalls input.
// The width*height*channels product runs as a registered multiply and a
// registered shift-add from the captured header words, ready well before the
// size word ends.
// Reset leaves the parser idle; bytes before the first start flag are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ktx_header_parse_extract_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         start_of_file_i,
  input  wire  [7:0]  file_byte_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [2:0]  channel_count_o,
  output logic [31:0] compression_format_o,
  output logic [33:0] data_size_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_payload_o
);
  import khpe_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  khpe_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .start_of_file_i (start_of_file_i),
    .out_ready_i     (out_ready_i),
    .status_i        (status),
    .in_ready_o      (in_ready_o),
    .out_valid_o     (out_valid_o),
    .cmd_o           (cmd)
  );

  khpe_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_of_file_i      (start_of_file_i),
    .file_byte_i          (file_byte_i),
    .cmd_i                (cmd),
    .status_o             (status),
    .result_kind_o        (result_kind_o),
    .error_code_o         (error_code_o),
    .image_width_o        (image_width_o),
    .image_height_o       (image_height_o),
    .channel_count_o      (channel_count_o),
    .compression_format_o (compression_format_o),
    .data_size_o          (data_size_o),
    .payload_byte_o       (payload_byte_o),
    .last_payload_o       (last_payload_o)
  );

endmodule

`default_nettype wire

[tb/sv/tb_ktx_header_parse_extract_core.sv]
// ----------------------------------------------------------------------------
// KTX header parser testbench
// Streams KTX version 1 files byte by byte into the parser, predicts every
// summary, payload byte and error report in a local parser model, and checks
// each output transaction in order. Covers header checks, key/value skipping,
// size saturation, restarts in mid-file, random traffic and output backpressure.
// ----------------------------------------------------------------------------
module tb_ktx_header_parse_extract_core;
  import khpe_pkg::*;

  localparam logic [95:0] KTX_IDENT = 96'hAB4B5458_203131BB_0D0A1A0A;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 250;
  localparam int KV_FILL_MAX  = 64;
  localparam int PAY_FILL_MAX = 400;
  localparam int ITEM_TARGET  = 1700;
  localparam int CALM_ITEMS   = 200;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  err;
    logic [15:0] wd;
    logic [15:0] ht;
    logic [2:0]  ch;
    logic [31:0] fmt;
    logic [33:0] size;
    logic [7:0]  pay;
    logic        last;
  } ktx_result_t;

  typedef struct packed {
    logic [31:0] endian;
    logic [31:0] typ;
    logic [31:0] fmt;
    logic [31:0] ifmt;
    logic [31:0] wd;
    logic [31:0] ht;
    logic [31:0] arr;
    logic [31:0] faces;
    logic [31:0] kvlen;
    logic [31:0] isize;
  } ktx_hdr_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        start_of_file = 1'b0;
  logic [7:0]  file_byte = 8'h00;
  logic        out_ready = 1'b0;
  wire         in_ready_o;
  wire         out_valid_o;
  wire  [1:0]  result_kind_o;
  wire  [1:0]  error_code_o;
  wire  [15:0] image_width_o;
  wire  [15:0] image_height_o;
  wire  [2:0]  channel_count_o;
  wire  [31:0] compression_format_o;
  wire  [33:0] data_size_o;
  wire  [7:0]  payload_byte_o;
  wire         last_payload_o;

  ktx_result_t expected_results[$];
  logic [7:0]  file_bytes[$];
  int          errors = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  bit          in_gaps_on = 1'b1;
  bit          out_stalls_on = 1'b1;
  bit          hold_req = 1'b0;

  // parser model state
  phase_e      phase = PH_IDLE;
  logic [31:0] byte_idx = '0;
  logic [31:0] word_sr = '0;
  logic        type_nz = 1'b0;
  logic [31:0] fmt_word = '0;
  logic [31:0] ifmt_word = '0;
  logic [31:0] hdr_width = '0;
  logic [31:0] hdr_height = '0;
  logic [31:0] kv_left = '0;
  logic [31:0] bytes_left = '0;

  ktx_header_parse_extract_core uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .start_of_file_i     (start_of_file),
    .file_byte_i         (file_byte),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .result_kind_o       (result_kind_o),
    .error_code_o        (error_code_o),
    .image_width_o       (image_width_o),
    .image_height_o      (image_height_o),
    .channel_count_o     (channel_count_o),
    .compression_format_o(compression_format_o),
    .data_size_o         (data_size_o),
    .payload_byte_o      (payload_byte_o),
    .last_payload_o      (last_payload_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL ktx_header_parse_extract_core");
      $finish;
    end
  end

  function automatic logic [15:0] clamp_dim(input logic [31:0] v);
    return (v > 32'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic flag_error(input logic [1:0] code);
    ktx_result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.err = code;
    expected_results.push_back(r);
    phase = PH_DONE;
  endtask

  task automatic parse_byte(input logic sof, input logic [7:0] b);
    ktx_result_t r;
    logic [31:0] p;
    logic [15:0] sw;
    logic [15:0] sh;
    if (sof) begin
      byte_idx = '0;
      word_sr = '0;
      type_nz = 1'b0;
      fmt_word = '0;
      ifmt_word = '0;
      hdr_width = '0;
      hdr_height = '0;
      kv_left = '0;
      bytes_left = '0;
      phase = PH_HEADER;
    end
    case (phase)
      PH_HEADER: begin
        p = byte_idx;
        word_sr = {b, word_sr[31:8]};
        byte_idx = p + 1;
        if (p < POS_IDENT_END) begin
          if (b != KTX_IDENT[95 - 8 * p -: 8]) flag_error(ERR_IDENT);
        end else if (p[1:0] == 2'b11) begin
          case (p)
            POS_ENDIAN:  if (word_sr != ENDIAN_TAG) flag_error(ERR_ENDIAN);
            POS_TYPE:    type_nz = (word_sr != 0);
            POS_FORMAT:  fmt_word = word_sr;
            POS_IFORMAT: ifmt_word = word_sr;
            POS_WIDTH:   hdr_width = word_sr;
            POS_HEIGHT:  hdr_height = word_sr;
            POS_ARRAY:   if (word_sr != 0) flag_error(ERR_ARRAY);
            POS_FACES:   if (word_sr != 1 && word_sr != 6) flag_error(ERR_FACES);
            POS_KVLEN: begin
              kv_left = word_sr;
              byte_idx = '0;
              phase = (word_sr == 0) ? PH_SIZE : PH_KVSKIP;
            end
            default: ;
          endcase
        end
      end
      PH_KVSKIP: begin
        kv_left = kv_left - 1;
        if (kv_left == 0) begin
          byte_idx = '0;
          phase = PH_SIZE;
        end
      end
      PH_SIZE: begin
        word_sr = {b, word_sr[31:8]};
        byte_idx = byte_idx + 1;
        if (byte_idx >= 4) begin
          bytes_left = word_sr;
          sw = clamp_dim(hdr_width);
          sh = clamp_dim(hdr_height);
          r = '0;
          r.kind = KIND_SUMMARY;
          r.wd = sw;
          r.ht = sh;
          r.ch = (fmt_word == RGB_FORMAT) ? 3'd3 : 3'd4;
          if (type_nz) begin
            r.size = {18'd0, sw} * {18'd0, sh} * {31'd0, r.ch};
          end else begin
            r.fmt = ifmt_word;
            r.size = {2'b00, word_sr};
          end
          expected_results.push_back(r);
          phase = (word_sr == 0) ? PH_DONE : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        bytes_left = bytes_left - 1;
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.pay = b;
        if (bytes_left == 0) begin
          r.last = 1'b1;
          phase = PH_DONE;
        end
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [33:0] want,
                             input logic [33:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    ktx_result_t want;
    if (rst_ni && in_valid && in_ready_o) parse_byte(start_of_file, file_byte);
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual kind %0d",
                 $time, result_kind_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", 34'(want.kind), 34'(result_kind_o));
        check_field("error_code", 34'(want.err), 34'(error_code_o));
        check_field("image_width", 34'(want.wd), 34'(image_width_o));
        check_field("image_height", 34'(want.ht), 34'(image_height_o));
        check_field("channel_count", 34'(want.ch), 34'(channel_count_o));
        check_field("compression_format", 34'(want.fmt), 34'(compression_format_o));
        check_field("data_size", want.size, data_size_o);
        check_field("payload_byte", 34'(want.pay), 34'(payload_byte_o));
        check_field("last_payload", 34'(want.last), 34'(last_payload_o));
      end
    end
  end

  initial begin : receiver
    int k;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready <= !(out_stalls_on && $urandom_range(99) < 23);
    end
  end

  task automatic send_byte(input logic sof, input logic [7:0] b);
    int gap;
    if (in_gaps_on && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    start_of_file <= sof;
    file_byte <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_bytes(input int n);
    int i;
    for (i = 0; i < n; i++) send_byte(i == 0, file_bytes[i]);
  endtask

  task automatic push_word(input logic [31:0] w);
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[31:24]);
  endtask

  task automatic build_file(input ktx_hdr_t h, input int n_trail);
    int i;
    file_bytes.delete();
    for (i = 0; i < 12; i++) file_bytes.push_back(KTX_IDENT[95 - 8 * i -: 8]);
    push_word(h.endian);
    push_word(h.typ);
    push_word($urandom_range(0, 4));
    push_word(h.fmt);
    push_word(h.ifmt);
    push_word($urandom);
    push_word(h.wd);
    push_word(h.ht);
    push_word($urandom_range(0, 1));
    push_word(h.arr);
    push_word(h.faces);
    push_word($urandom_range(1, 12));
    push_word(h.kvlen);
    for (i = 0; i < h.kvlen && i < KV_FILL_MAX; i++) file_bytes.push_back(8'($urandom));
    push_word(h.isize);
    for (i = 0; i < h.isize && i < PAY_FILL_MAX; i++) file_bytes.push_back(8'($urandom));
    for (i = 0; i < n_trail; i++) file_bytes.push_back(8'($urandom));
  endtask

  task automatic send_file(input ktx_hdr_t h, input int n_trail);
    build_file(h, n_trail);
    send_bytes(file_bytes.size());
  endtask

  task automatic corrupt_ident(input int idx);
    file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
  endtask

  function automatic logic [31:0] random_dim();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return $urandom;
      2:       return 32'd65535;
      3:       return 32'd65536;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic ktx_hdr_t random_hdr();
    ktx_hdr_t h;
    h.endian = ENDIAN_TAG;
    h.typ = $urandom_range(1) ? 32'd0 : $urandom;
    h.fmt = ($urandom_range(99) < 40) ? RGB_FORMAT : $urandom;
    h.ifmt = $urandom;
    h.wd = random_dim();
    h.ht = random_dim();
    h.arr = 32'd0;
    h.faces = $urandom_range(1) ? 32'd1 : 32'd6;
    h.kvlen = ($urandom_range(99) < 35) ? 32'd0 : $urandom_range(1, 20);
    h.isize = ($urandom_range(99) < 10) ? 32'd0 : $urandom_range(1, 40);
    return h;
  endfunction

  task automatic test_idle_bytes;
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'hAB);
  endtask

  task automatic test_well_formed;
    ktx_hdr_t h;
    h = random_hdr();
    h.typ = 32'h1401; h.fmt = RGB_FORMAT; h.wd = 4; h.ht = 2; h.kvlen = 0; h.isize = 24;
    send_file(h, 0);
    h = random_hdr();
    h.typ = 0; h.ifmt = 32'h8E64; h.kvlen = 8; h.isize = 16;
    send_file(h, 5);
    h = random_hdr();
    h.typ = 32'hFFFFFFFF; h.fmt = 32'h1908; h.wd = 32'hFFFFFFFF; h.ht = 32'd65536;
    h.isize = 3;
    send_file(h, 2);
    h = random_hdr();
    h.isize = 0; h.kvlen = 1; h.faces = 6;
    send_file(h, 4);
    h = random_hdr();
    h.typ = 1; h.wd = 65535; h.ht = 0; h.isize = 1;
    send_file(h, 0);
  endtask

  task automatic test_header_errors;
    ktx_hdr_t h;
    h = random_hdr();
    build_file(h, 0);
    corrupt_ident(0);
    send_bytes(file_bytes.size());
    build_file(h, 0);
    corrupt_ident(11);
    send_bytes(file_bytes.size());
    h.endian = 32'h01020304;
    send_file(h, 0);
    h.endian = ENDIAN_TAG;
    h.arr = 1;
    send_file(h, 0);
    h.arr = 32'hFFFFFFFF;
    send_file(h, 0);
    h.arr = 0;
    h.faces = 0;
    send_file(h, 0);
    h.faces = 2;
    send_file(h, 0);
  endtask

  task automatic test_restart;
    ktx_hdr_t h;
    h = random_hdr();
    build_file(h, 0);
    send_bytes(5);
    send_bytes(40);
    h.kvlen = 32'hFFFFFFFF;
    build_file(h, 0);
    send_bytes(70);
    h.kvlen = 0;
    h.isize = 32'hFFFFFFFF;
    build_file(h, 0);
    send_bytes(80);
    h = random_hdr();
    send_file(h, 0);
  endtask

  task automatic test_backpressure;
    ktx_hdr_t h;
    h = random_hdr();
    h.kvlen = 0;
    h.isize = 150;
    hold_req = 1'b1;
    send_file(h, 0);
  endtask

  task automatic test_random;
    ktx_hdr_t h;
    int unsigned calm_end;
    int pick;
    int cut;
    logic [1:0] sel;
    calm_end = items_sent + CALM_ITEMS;
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    while (items_sent < ITEM_TARGET || items_sent < calm_end) begin
      if (items_sent >= calm_end) begin
        in_gaps_on = 1'b1;
        out_stalls_on = 1'b1;
      end
      h = random_hdr();
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_file(h, $urandom_range(0, 4));
      end else if (pick < 82) begin
        sel = 2'($urandom_range(3));
        case (sel)
          ERR_ENDIAN: do h.endian = $urandom; while (h.endian == ENDIAN_TAG);
          ERR_ARRAY:  do h.arr = $urandom_range(1) ? $urandom_range(1, 4) : $urandom;
                      while (h.arr == 0);
          ERR_FACES:  do h.faces = $urandom_range(1) ? $urandom_range(0, 8) : $urandom;
                      while (h.faces == 1 || h.faces == 6);
          default: ;
        endcase
        build_file(h, 0);
        if (sel == ERR_IDENT) corrupt_ident($urandom_range(0, 11));
        send_bytes(file_bytes.size());
      end else if (pick < 92) begin
        if ($urandom_range(1)) h.isize = $urandom;
        build_file(h, 0);
        cut = $urandom_range(1, file_bytes.size() - 1);
        send_bytes(cut);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(1'b0, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_bytes();
    test_well_formed();
    test_header_errors();
    test_restart();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS ktx_header_parse_extract_core");
    end else begin
      $display("FAIL ktx_header_parse_extract_core");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/khpe_pkg.sv
sv/khpe_ctrl.sv
sv/khpe_dp.sv
sv/ktx_header_parse_extract_core.sv
tb/sv/tb_ktx_header_parse_extract_core.sv
